// ----- sv/lcd_glyph_bitmap_draw_engine_unit_macros.svh -----
// Assertion macros for the glyph bitmap draw engine.
// No dependencies.
`ifndef LCD_GLYPH_BITMAP_DRAW_ENGINE_UNIT_MACROS_SVH
`define LCD_GLYPH_BITMAP_DRAW_ENGINE_UNIT_MACROS_SVH
`define LGB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LGB_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- sv/lgb_pkg.sv -----
// Shared command codes for the glyph bitmap draw engine.
// No dependencies.
package lgb_pkg;
  typedef enum logic [2:0] {
    K_CLEAR = 3'd0, K_PIXEL = 3'd1, K_LINE = 3'd2, K_RECT = 3'd3,
    K_FILL = 3'd4, K_INVERT = 3'd5, K_REFRESH = 3'd6, K_NONE = 3'd7
  } kind_e;
endpackage

// ----- sv/lcd_glyph_bitmap_draw_engine_unit.sv -----
// Top level of the glyph bitmap draw engine: sequencer, row memory, glyph emitter.
// Depends on lgb_pkg and the macros header.
//
// Channel | Dir | Beat
// s_axis  | in  | tuser: kind[2:0]; tdata: x_start[4:0] y_start[8:5] x_end[13:9]
//         |     |        y_end[17:14] color[18] refresh[19]
// m_axis  | out | tdata: glyph_index[2:0] glyph_row[5:3] row_bits[10:6]; tlast = last
//
// One command at a time; s_axis_tready is high only while idle.
// Reset runs a clearing sweep of the rows, one per cycle (16 by default), before the first beat.
// Clear and invert sweep the rows the same way, then emit.
// Pixels, lines and outline sides take a setup state per segment, then visit each pixel with a
// memory read, then write back; a filled rectangle visits each of its pixels the same way, row by row.
// A refresh emits 2*GLYPHS_ACROSS*GLYPH_HEIGHT beats, each read in S_EMIT and sent from S_WAIT; a stall holds it.
`include "lcd_glyph_bitmap_draw_engine_unit_macros.svh"
module lcd_glyph_bitmap_draw_engine_unit
  import lgb_pkg::*;
#(
  parameter int GLYPH_WIDTH   = 5,
  parameter int GLYPH_HEIGHT  = 8,
  parameter int GLYPHS_ACROSS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,  // kind
  input  logic [23:0] s_axis_tdata,  // x_start, y_start, x_end, y_end, color, refresh
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // glyph_index, glyph_row, row_bits
  output logic        m_axis_tlast
);
  localparam int BW = GLYPH_WIDTH * GLYPHS_ACROSS;
  localparam int BH = GLYPH_HEIGHT * 2;
  localparam int YW = $clog2(BH);
  localparam int GC = GLYPHS_ACROSS * 2;
  localparam int GRW = $clog2(GLYPH_HEIGHT);
  localparam int GXW = (GLYPHS_ACROSS > 1) ? $clog2(GLYPHS_ACROSS) : 1;

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_SWEEP = 4'd2,
    S_RD = 4'd3, S_WR = 4'd4, S_EMIT = 4'd5, S_WAIT = 4'd6, S_NEXT = 4'd7;

  logic [BW-1:0] mem [BH];
  logic [BW-1:0] rdata_q;
  logic [3:0]    st_q;
  logic [YW-1:0] row_q;
  logic [2:0]    kind_q;
  logic          color_q, emit_q;
  logic [1:0]    seg_q;
  logic signed [6:0] x_q, y_q, x1_q, y1_q, err_q, dx_q, dy_q;
  logic signed [6:0] sx_q, sy_q;
  logic signed [6:0] xs_q, ys_q, xe_q, ye_q, xl_q, fx_q;
  logic [2:0]    gi_q;
  logic [GRW-1:0] gr_q;

  wire [2:0] in_kind = s_axis_tuser;
  wire in_refresh = s_axis_tdata[19];
  assign s_axis_tready = (st_q == S_IDLE);
  wire acc = s_axis_tvalid && s_axis_tready;

  // pixel target in range
  wire on_bmp = (x_q >= 0) && (x_q < BW) && (y_q >= 0) && (y_q < BH);
  wire [YW-1:0] y_idx = y_q[YW-1:0];

  logic signed [7:0] e2;
  assign e2 = {err_q, 1'b0};

  // emit read: glyph row maps to bitmap row
  wire [YW-1:0] emit_row = YW'((gi_q >= GC/2 ? GLYPH_HEIGHT : 0) + gr_q);
  logic [GXW-1:0] gx;
  assign gx = GXW'((gi_q >= 3'(GLYPHS_ACROSS)) ? gi_q - 3'(GLYPHS_ACROSS) : gi_q);

  logic [4:0] bits;
  always_comb begin
    bits = '0;
    for (int k = 0; k < GLYPH_WIDTH; k++)
      if (GLYPH_WIDTH - 1 - k < 5) bits[GLYPH_WIDTH-1-k] = rdata_q[gx*GLYPH_WIDTH + k];
  end

  logic mem_we;
  logic [YW-1:0] mem_wa, mem_ra;
  logic [BW-1:0] mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = row_q;
    mem_wd = '0;
    mem_ra = emit_row;
    if (st_q == S_INIT) begin
      mem_we = 1'b1;
    end else if (st_q == S_SWEEP) begin
      mem_we = 1'b1;
      mem_wd = (kind_q == K_INVERT) ? ~rdata_q : '0;
    end else if (st_q == S_WR && on_bmp) begin
      mem_we = 1'b1;
      mem_wa = y_idx;
      mem_wd = rdata_q;
      mem_wd[x_q[4:0]] = color_q;
    end
    if (st_q == S_RD) mem_ra = y_idx;
    if (st_q == S_IDLE) mem_ra = '0;
    if (st_q == S_SWEEP) mem_ra = last_row ? '0 : row_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

  wire last_row = (row_q == YW'(BH-1));
  wire at_end = (x_q == x1_q) && (y_q == y1_q);
  wire out_fire = m_axis_tvalid && m_axis_tready;
  wire out_stall = m_axis_tvalid && !m_axis_tready;
  wire last_gi = (m_axis_tdata[2:0] == 3'(GC-1));

  function automatic logic signed [6:0] absd(logic signed [6:0] a, logic signed [6:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic start_line(input logic signed [6:0] a, input logic signed [6:0] b,
                            input logic signed [6:0] c, input logic signed [6:0] d);
    x_q <= a; y_q <= b; x1_q <= c; y1_q <= d;
    dx_q <= absd(a, c); dy_q <= absd(b, d);
    err_q <= absd(a, c) - absd(b, d);
    sx_q <= (a < c) ? 7'sd1 : -7'sd1;
    sy_q <= (b < d) ? 7'sd1 : -7'sd1;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; row_q <= '0; m_axis_tvalid <= 1'b0; kind_q <= K_NONE;
      emit_q <= 1'b0; seg_q <= '0; gi_q <= '0; gr_q <= '0;
    end else begin
      unique case (st_q)
        S_INIT: begin
          row_q <= row_q + 1'b1;
          if (last_row) begin st_q <= S_IDLE; row_q <= '0; end
        end
        S_IDLE: if (acc) begin
          kind_q  <= in_kind;
          color_q <= s_axis_tdata[18];
          emit_q  <= in_refresh || in_kind == K_CLEAR || in_kind == K_INVERT
                     || in_kind == K_REFRESH;
          xs_q <= 7'(s_axis_tdata[4:0]);   ys_q <= 7'(s_axis_tdata[8:5]);
          xe_q <= 7'(s_axis_tdata[13:9]);  ye_q <= 7'(s_axis_tdata[17:14]);
          seg_q <= '0; row_q <= '0; gi_q <= '0; gr_q <= '0;
          unique case (in_kind)
            K_CLEAR, K_INVERT: st_q <= S_SWEEP;
            K_PIXEL, K_LINE, K_RECT, K_FILL: st_q <= S_NEXT;
            default: st_q <= (in_refresh || in_kind == K_REFRESH) ? S_EMIT : S_IDLE;
          endcase
        end
        S_SWEEP: begin
          // rdata_q holds row_q: it was read as the next row in the previous cycle
          row_q <= row_q + 1'b1;
          if (last_row) begin st_q <= S_EMIT; row_q <= '0; end
        end
        S_NEXT: begin
          // set up the next segment
          st_q <= S_RD;
          unique case (kind_q)
            K_PIXEL: start_line(xs_q, ys_q, xs_q, ys_q);
            K_LINE:  start_line(xs_q, ys_q, xe_q, ye_q);
            K_RECT: begin
              unique case (seg_q)
                2'd0: start_line(xs_q, ys_q, xe_q, ys_q);
                2'd1: start_line(xs_q, ye_q, xe_q, ye_q);
                2'd2: start_line(xs_q, ys_q, xs_q, ye_q);
                default: start_line(xe_q, ys_q, xe_q, ye_q);
              endcase
            end
            default: begin
              xl_q <= (xs_q < xe_q) ? xs_q : xe_q;
              fx_q <= (xs_q < xe_q) ? xe_q : xs_q;
              start_line((xs_q < xe_q) ? xs_q : xe_q, (ys_q < ye_q) ? ys_q : ye_q,
                         (xs_q < xe_q) ? xs_q : xe_q, (ys_q < ye_q) ? ye_q : ys_q);
            end
          endcase
        end
        S_RD: st_q <= S_WR;
        S_WR: begin
          st_q <= S_RD;
          if (kind_q == K_FILL) begin
            if (x_q == fx_q) begin
              if (y_q == y1_q) st_q <= emit_q ? S_EMIT : S_IDLE;
              else begin x_q <= xl_q; y_q <= y_q + 7'sd1; end
            end else x_q <= x_q + 7'sd1;
          end else if (at_end) begin
            if (kind_q == K_RECT && seg_q != 2'd3) begin
              seg_q <= seg_q + 1'b1; st_q <= S_NEXT;
            end else st_q <= emit_q ? S_EMIT : S_IDLE;
          end else begin
            if (e2 > -dy_q && e2 < dx_q) err_q <= err_q - dy_q + dx_q;
            else if (e2 > -dy_q) err_q <= err_q - dy_q;
            else if (e2 < dx_q) err_q <= err_q + dx_q;
            if (e2 > -dy_q) x_q <= x_q + sx_q;
            if (e2 < dx_q) y_q <= y_q + sy_q;
          end
        end
        S_EMIT: begin
          // read issued this cycle with emit_row; data next cycle
          st_q <= S_WAIT;
        end
        S_WAIT: begin
          if (!m_axis_tvalid || out_fire) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {5'd0, bits, 3'(gr_q), gi_q};
            m_axis_tlast <= (gi_q == 3'(GC-1)) && (gr_q == GRW'(GLYPH_HEIGHT-1));
            if ((gi_q == 3'(GC-1)) && (gr_q == GRW'(GLYPH_HEIGHT-1))) st_q <= S_IDLE;
            else begin
              st_q <= S_EMIT;
              if (gr_q == GRW'(GLYPH_HEIGHT-1)) begin gr_q <= '0; gi_q <= gi_q + 1'b1; end
              else gr_q <= gr_q + 1'b1;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
      if (out_fire && !(st_q == S_WAIT)) m_axis_tvalid <= 1'b0;
    end
  end

  `LGB_ASSERT(a_no_take_busy, clk_i, rst_ni, (st_q != S_IDLE) |-> !s_axis_tready, "ready while busy")
  `LGB_ASSERT(a_last_valid, clk_i, rst_ni, m_axis_tlast && m_axis_tvalid |-> last_gi, "last on wrong glyph")
  `LGB_ASSERT(a_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "beat changed")
endmodule
